FILE: rtl/mbrx_pkg.sv
// ----------------------------------------------------------------------------
// mbrx_pkg: shared definitions of the Modbus RTU response receiver
// Frame geometry, input and status codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package mbrx_pkg;

	localparam int FRAME_BYTES = 32;
	localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
	localparam int ADDR_W      = $clog2(FRAME_BYTES);
	localparam int LEN_W       = 9;
	localparam int MAX_WORDS   = 13;
	localparam int WORD_W      = 4;

	// Frame layout.
	localparam int FIXED_LEN   = 5;
	localparam int DATA_START  = 3;
	localparam int EXC_BIT     = 7;

	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] TICK_MAX = 16'hFFFF;

	localparam logic [7:0]  SLAVE_ADDR_RST = 8'd1;
	localparam logic [15:0] TIMEOUT_RST    = 16'd100;

	typedef enum logic [1:0] {
		CMD_ARM  = 2'd0,
		CMD_BYTE = 2'd1,
		CMD_TICK = 2'd2,
		CMD_NONE = 2'd3
	} in_cmd_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_CRC_ERR  = 3'd1,
		ST_BAD_ADDR = 3'd2,
		ST_EXCEPT   = 3'd3,
		ST_TIMEOUT  = 3'd4,
		ST_OVERFLOW = 3'd5
	} rsp_status_t;

	typedef enum logic {
		REG_SLAVE_ADDR = 1'b0,
		REG_TIMEOUT    = 1'b1
	} cfg_reg_t;

	// Controller to datapath.
	typedef struct packed {
		logic take;
		logic crc_step;
		logic check;
		logic ld_st;
		logic ld_wd;
		logic rd;
		logic rd_lo;
	} ctl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic to_emit;
		logic to_crc;
		logic crc_done;
		logic chk_emit;
		logic out_free;
		logic words_zero;
		logic last_word;
	} dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/mbrx_ctl.sv
// ----------------------------------------------------------------------------
// mbrx_ctl: receiver controller
// Sequences byte intake, the bit-serial CRC update, the frame check and the
// readout of status and register word results.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrx_ctl
	import mbrx_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	input  wire dp_sts_t  sts,
	output ctl_cmd_t      cmd
);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_CRC     = 7'b0000010,
		S_CHECK   = 7'b0000100,
		S_EMIT_ST = 7'b0001000,
		S_RD_HI   = 7'b0010000,
		S_RD_LO   = 7'b0100000,
		S_EMIT_WD = 7'b1000000
	} state_t;

	state_t state_q, state_nx;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.take = s_tvalid;
				if (sts.to_emit) begin
					state_nx = S_EMIT_ST;
				end else if (sts.to_crc) begin
					state_nx = S_CRC;
				end
			end
			S_CRC: begin
				cmd.crc_step = 1'b1;
				if (sts.crc_done) begin
					state_nx = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_nx  = sts.chk_emit ? S_EMIT_ST : S_IDLE;
			end
			S_EMIT_ST: begin
				if (sts.out_free) begin
					cmd.ld_st = 1'b1;
					state_nx  = sts.words_zero ? S_IDLE : S_RD_HI;
				end
			end
			S_RD_HI: begin
				cmd.rd   = 1'b1;
				state_nx = S_RD_LO;
			end
			S_RD_LO: begin
				cmd.rd    = 1'b1;
				cmd.rd_lo = 1'b1;
				state_nx  = S_EMIT_WD;
			end
			S_EMIT_WD: begin
				if (sts.out_free) begin
					cmd.ld_wd = 1'b1;
					state_nx  = sts.last_word ? S_IDLE : S_RD_HI;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/mbrx_dp.sv
// ----------------------------------------------------------------------------
// mbrx_dp: receiver datapath
// Frame store, byte counter, tick timer, delayed bit-serial CRC-16, frame
// checks, configuration registers and the output result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrx_dp
	import mbrx_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ctl_cmd_t    cmd,
	output dp_sts_t          sts,
	input  wire logic [1:0]  in_cmd,
	input  wire logic [7:0]  in_byte,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,
	output logic [0:0]       m_tuser,
	output logic             m_tlast
);

	logic [7:0]        mem [FRAME_BYTES];
	logic [7:0]        slave_addr_q;
	logic [15:0]       timeout_q;
	logic              active_q;
	logic [CNT_W-1:0]  count_q;
	logic [15:0]       elapsed_q;
	logic [7:0]        addr_byte_q, func_q, bcnt_q;
	logic [7:0]        prev1_q, prev2_q;
	logic [15:0]       crc_q;
	logic [2:0]        bit_q;
	logic [2:0]        code_q;
	logic [7:0]        exc_q;
	logic [WORD_W-1:0] words_q, widx_q;
	logic [7:0]        rd_q, hi_q;
	logic              out_valid_q, out_isreg_q, out_last_q;
	logic [2:0]        out_status_q;
	logic [7:0]        out_exc_q;
	logic [WORD_W-1:0] out_idx_q;
	logic [15:0]       out_val_q;

	logic              is_arm, is_byte, is_tick;
	logic              full, fold;
	logic [15:0]       elapsed_nx;
	logic              tick_hit, arm_ok;
	logic              exc, have_len, too_long, done;
	logic [LEN_W-1:0]  expected, count_ext;
	logic [CNT_W-1:0]  words_raw;
	logic [WORD_W-1:0] words_nx;
	logic [2:0]        chk_code;
	logic [ADDR_W-1:0] rd_addr;

	assign is_arm  = cmd.take && (in_cmd == CMD_ARM);
	assign is_byte = cmd.take && (in_cmd == CMD_BYTE) && active_q;
	assign is_tick = cmd.take && (in_cmd == CMD_TICK) && active_q;
	assign full    = (count_q == CNT_W'(FRAME_BYTES));
	// The CRC runs two bytes behind the store so that it never covers the
	// trailing CRC field, whatever length the frame turns out to have.
	assign fold    = (count_q >= CNT_W'(2));

	assign elapsed_nx = (elapsed_q == TICK_MAX) ? TICK_MAX : elapsed_q + 16'd1;
	assign tick_hit   = (elapsed_nx >= timeout_q);
	assign arm_ok     = !(active_q && (elapsed_q < timeout_q));

	assign exc       = func_q[EXC_BIT];
	assign count_ext = LEN_W'(count_q);
	assign have_len  = exc || (count_q >= CNT_W'(DATA_START));
	assign too_long  = !exc && (count_q >= CNT_W'(DATA_START)) &&
		((LEN_W'(bcnt_q) + LEN_W'(FIXED_LEN)) > LEN_W'(FRAME_BYTES));
	assign expected  = exc ? LEN_W'(FIXED_LEN) : LEN_W'(bcnt_q) + LEN_W'(FIXED_LEN);
	assign done      = have_len && !too_long && (count_ext >= expected);
	assign words_raw = (count_q - CNT_W'(FIXED_LEN)) >> 1;
	assign words_nx  = (words_raw > CNT_W'(MAX_WORDS)) ? WORD_W'(MAX_WORDS)
		: WORD_W'(words_raw);

	always_comb begin
		if (too_long) begin
			chk_code = ST_OVERFLOW;
		end else if (crc_q != {prev1_q, prev2_q}) begin
			chk_code = ST_CRC_ERR;
		end else if (addr_byte_q != slave_addr_q) begin
			chk_code = ST_BAD_ADDR;
		end else if (exc) begin
			chk_code = ST_EXCEPT;
		end else begin
			chk_code = ST_OK;
		end
	end

	assign rd_addr = ADDR_W'(DATA_START) + ADDR_W'({widx_q, 1'b0}) + ADDR_W'(cmd.rd_lo);

	assign sts.to_emit    = (is_tick && tick_hit) || (is_byte && full);
	assign sts.to_crc     = is_byte && !full && fold;
	assign sts.crc_done   = (bit_q == 3'd7);
	assign sts.chk_emit   = too_long || done;
	assign sts.out_free   = !out_valid_q || m_tready;
	assign sts.words_zero = (words_q == '0);
	assign sts.last_word  = ((widx_q + WORD_W'(1)) == words_q);

	// Configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= SLAVE_ADDR_RST;
			timeout_q    <= TIMEOUT_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_SLAVE_ADDR) begin
				slave_addr_q <= cfg_data[7:0];
			end else begin
				timeout_q <= cfg_data;
			end
		end
	end

	// Read state, byte counter and timer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			count_q   <= '0;
			elapsed_q <= '0;
			bit_q     <= '0;
			widx_q    <= '0;
		end else begin
			if (is_arm && arm_ok) begin
				active_q  <= 1'b1;
				count_q   <= '0;
				elapsed_q <= '0;
			end
			if (is_tick) begin
				elapsed_q <= elapsed_nx;
				if (tick_hit) begin
					active_q <= 1'b0;
				end
			end
			if (is_byte) begin
				if (full) begin
					active_q <= 1'b0;
					count_q  <= '0;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (cmd.check && sts.chk_emit) begin
				active_q <= 1'b0;
				if (too_long) begin
					count_q <= '0;
				end
			end
			if (cmd.take) begin
				bit_q <= '0;
			end else if (cmd.crc_step) begin
				bit_q <= bit_q + 3'd1;
			end
			if (cmd.ld_st) begin
				widx_q <= '0;
			end else if (cmd.ld_wd) begin
				widx_q <= widx_q + WORD_W'(1);
			end
		end
	end

	// Frame bytes, CRC and result fields.
	always_ff @(posedge clk) begin
		if (is_arm && arm_ok) begin
			crc_q <= CRC_INIT;
		end
		if (is_byte && !full) begin
			mem[count_q[ADDR_W-1:0]] <= in_byte;
			prev1_q <= in_byte;
			prev2_q <= prev1_q;
			if (fold) begin
				crc_q <= crc_q ^ {8'h00, prev2_q};
			end
			if (count_q == CNT_W'(0)) begin
				addr_byte_q <= in_byte;
			end
			if (count_q == CNT_W'(1)) begin
				func_q <= in_byte;
			end
			if (count_q == CNT_W'(2)) begin
				bcnt_q <= in_byte;
			end
		end
		if (cmd.crc_step) begin
			crc_q <= crc_q[0] ? ((crc_q >> 1) ^ CRC_POLY) : (crc_q >> 1);
		end
		if (sts.to_emit) begin
			code_q  <= (is_tick) ? ST_TIMEOUT : ST_OVERFLOW;
			exc_q   <= '0;
			words_q <= '0;
		end
		if (cmd.check && sts.chk_emit) begin
			code_q  <= chk_code;
			exc_q   <= (chk_code == ST_EXCEPT) ? bcnt_q : 8'h00;
			words_q <= (chk_code == ST_OK) ? words_nx : '0;
		end
		if (cmd.rd) begin
			rd_q <= mem[rd_addr];
		end
		if (cmd.rd_lo) begin
			hi_q <= rd_q;
		end
		if (cmd.ld_st) begin
			out_isreg_q  <= 1'b0;
			out_status_q <= code_q;
			out_exc_q    <= exc_q;
			out_idx_q    <= '0;
			out_val_q    <= '0;
			out_last_q   <= (words_q == '0);
		end else if (cmd.ld_wd) begin
			out_isreg_q  <= 1'b1;
			out_status_q <= ST_OK;
			out_exc_q    <= '0;
			out_idx_q    <= widx_q;
			out_val_q    <= {hi_q, rd_q};
			out_last_q   <= sts.last_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ld_st || cmd.ld_wd) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_val_q, out_idx_q, out_exc_q, out_status_q};
	assign m_tuser  = out_isreg_q;
	assign m_tlast  = out_last_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !(cmd.ld_st || cmd.ld_wd))
		else $error("result register loaded while a beat is stalled");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FRAME_BYTES))
		else $error("byte counter beyond frame store");

	a_end_of_read: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.check && sts.chk_emit) |=> !active_q)
		else $error("read still active after frame completed");

	a_word_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_wd |-> (widx_q < words_q))
		else $error("register word index past word count");

endmodule

`default_nettype wire

FILE: rtl/modbus_rtu_response_receiver.sv
// ----------------------------------------------------------------------------
// modbus_rtu_response_receiver: Modbus RTU response frame receiver
// Collects a response frame after an arm beat, checks CRC-16 and address,
// and returns a status result followed by the register words.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  s_*      in         tuser: cmd; tdata: rx_byte
//  m_*      out        tuser: is_register; tdata: status, exception_code,
//                      reg_index, reg_value; tlast: last
//  cfg_*    in         index 0 slave_address, index 1 timeout_ticks
//
// An arm, an ignored beat or a tick that does not time out is only taken.
// A received byte is taken and, from the third byte on, then passes the
// bit-serial CRC update that folds one bit per cycle, and then the frame
// check. A beat that ends the read then loads the status beat, and each
// register word is then read as its high byte and its low byte and loaded.
// Reset clears the read state and loads the register reset values; the
// frame store is not cleared. A stalled result beat holds the block in its
// readout, while a single result waits without blocking further input.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_response_receiver
	import mbrx_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire logic [1:0]  s_tuser,   // [1:0] cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [2:0] status, [10:3] exception_code,
	                                    // [14:11] reg_index, [30:15] reg_value
	output logic [0:0]       m_tuser,   // [0] is_register
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data
);

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	mbrx_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mbrx_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_cmd    (s_tuser),
		.in_byte   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the Modbus RTU response receiver
// A stimulus table walks every status code and the corner cases first.
// Random phases under several register settings follow, with well-formed
// frames, broken frames, ticks and noise beats. A cycle-free predictor
// computes the result beats, which are compared field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import mbrx_pkg::*;

	typedef struct {
		logic        is_reg;
		rsp_status_t status;
		logic [7:0]  exc_code;
		logic [3:0]  reg_idx;
		logic [15:0] reg_val;
		logic        last;
	} rsp_t;

	typedef enum {CRC_NO, CRC_LO, CRC_HI, CRC_BAD} crc_pick_t;
	typedef enum {EXP_MODEL, EXP_NONE, EXP_STATUS} exp_kind_t;

	typedef struct {
		in_cmd_t     cmd;
		logic [7:0]  data;
		crc_pick_t   crc;
		exp_kind_t   how;
		rsp_status_t st;
		logic [7:0]  exc;
	} row_t;

	localparam int PLAN_ROWS = 38;
	localparam int TMO_ROW   = 35;
	localparam int PHASES    = 5;
	localparam int PHASE_ITEMS = 76;
	localparam int SETTLE_CYCLES = 200;
	localparam int HOLD_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	// Predictor state and its copy of the registers.
	logic [7:0]  rx_frame [FRAME_BYTES];
	int          rx_len;
	bit          rd_busy;
	logic [15:0] tick_cnt;
	logic [7:0]  cfg_slave;
	logic [15:0] cfg_timeout;

	rsp_t awaited_rsp[$];
	rsp_t new_rsp[$];

	int  errors;
	int  beats_in;
	int  items_taken;
	int  phase_items;
	int  beats_out;
	int  settings;
	int  st_seen [6];
	bit  calm;
	bit  hold_req;
	bit  hold_used;
	int  hold_left;
	row_t plan [PLAN_ROWS];

	modbus_rtu_response_receiver DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [15:0] crc_fold(logic [15:0] c, logic [7:0] b);
		c = c ^ {8'h00, b};
		repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	function automatic void add_rsp(logic is_reg, rsp_status_t st, logic [7:0] exc,
			logic [3:0] idx, logic [15:0] val, logic lst);
		rsp_t r;
		r.is_reg = is_reg;
		r.status = st;
		r.exc_code = exc;
		r.reg_idx = idx;
		r.reg_val = val;
		r.last = lst;
		new_rsp.push_back(r);
	endfunction

	function automatic void close_frame(int len);
		logic [15:0] crc;
		int words;
		crc = CRC_INIT;
		for (int i = 0; i < len - 2; i++)
			crc = crc_fold(crc, rx_frame[i]);
		if ({rx_frame[len-1], rx_frame[len-2]} != crc) begin
			add_rsp(1'b0, ST_CRC_ERR, 8'h00, 4'd0, 16'h0000, 1'b1);
		end else if (rx_frame[0] != cfg_slave) begin
			add_rsp(1'b0, ST_BAD_ADDR, 8'h00, 4'd0, 16'h0000, 1'b1);
		end else if (rx_frame[1][EXC_BIT]) begin
			add_rsp(1'b0, ST_EXCEPT, rx_frame[2], 4'd0, 16'h0000, 1'b1);
		end else begin
			words = (len - FIXED_LEN) / 2;
			if (words > MAX_WORDS)
				words = MAX_WORDS;
			add_rsp(1'b0, ST_OK, 8'h00, 4'd0, 16'h0000, words == 0);
			for (int w = 0; w < words; w++)
				add_rsp(1'b1, ST_OK, 8'h00, 4'(w),
					{rx_frame[DATA_START + 2*w], rx_frame[DATA_START + 2*w + 1]},
					w == words - 1);
		end
	endfunction

	// Works out the result beats of one accepted input beat into new_rsp.
	// took is cleared for beats that the block merely ignores.
	task automatic predict_response(input in_cmd_t cmd, input logic [7:0] b, output bit took);
		int need;
		new_rsp.delete();
		took = 1'b0;
		case (cmd)
			CMD_ARM: begin
				if (!(rd_busy && tick_cnt < cfg_timeout)) begin
					rd_busy = 1'b1;
					rx_len = 0;
					tick_cnt = 16'd0;
					took = 1'b1;
				end
			end
			CMD_TICK: begin
				if (rd_busy) begin
					took = 1'b1;
					if (tick_cnt != TICK_MAX)
						tick_cnt = tick_cnt + 16'd1;
					if (tick_cnt >= cfg_timeout) begin
						rd_busy = 1'b0;
						add_rsp(1'b0, ST_TIMEOUT, 8'h00, 4'd0, 16'h0000, 1'b1);
					end
				end
			end
			CMD_BYTE: begin
				if (rd_busy) begin
					took = 1'b1;
					if (rx_len >= FRAME_BYTES) begin
						rd_busy = 1'b0;
						rx_len = 0;
						add_rsp(1'b0, ST_OVERFLOW, 8'h00, 4'd0, 16'h0000, 1'b1);
					end else begin
						rx_frame[rx_len] = b;
						rx_len++;
						need = 0;
						if (rx_len >= 2 && rx_frame[1][EXC_BIT])
							need = FIXED_LEN;
						else if (rx_len >= 3)
							need = FIXED_LEN + rx_frame[2];
						if (need > FRAME_BYTES) begin
							rd_busy = 1'b0;
							rx_len = 0;
							add_rsp(1'b0, ST_OVERFLOW, 8'h00, 4'd0, 16'h0000, 1'b1);
						end else if (need != 0 && rx_len >= need) begin
							rd_busy = 1'b0;
							close_frame(need);
						end
					end
				end
			end
			default: ;
		endcase
	endtask

	// Offers one beat, waits for it to be taken and queues what it should cause.
	// Called and returning at a falling edge.
	task automatic send_beat(input in_cmd_t cmd, input logic [7:0] b, input exp_kind_t how,
			input rsp_status_t st, input logic [7:0] exc);
		bit took;
		while (!calm && $urandom_range(0, 99) < 37) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_response(cmd, b, took);
		beats_in++;
		phase_items++;
		if (took)
			items_taken++;
		if (how == EXP_STATUS)
			awaited_rsp.push_back('{1'b0, st, exc, 4'd0, 16'h0000, 1'b1});
		else if (how == EXP_MODEL)
			foreach (new_rsp[i])
				awaited_rsp.push_back(new_rsp[i]);
		@(negedge clk);
	endtask

	task automatic offer(input in_cmd_t cmd, input logic [7:0] b);
		send_beat(cmd, b, EXP_MODEL, ST_OK, 8'h00);
	endtask

	// Quiet the sender until every result is back, then give a block that is
	// still chewing on a beat without a result time to finish.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_regs(input logic [7:0] addr, input logic [15:0] tmo);
		cfg_we <= 1'b1;
		cfg_index <= REG_SLAVE_ADDR;
		cfg_data <= {8'h00, addr};
		@(negedge clk);
		cfg_index <= REG_TIMEOUT;
		cfg_data <= tmo;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_slave = addr;
		cfg_timeout = tmo;
		settings++;
	endtask

	// One response frame with random content. Most are well formed; some lose
	// their arm, carry a bad checksum, announce too many bytes or stop early.
	task automatic send_frame();
		logic [7:0] fr[$];
		logic [15:0] crc;
		int pick;
		int n;
		int k;
		int keep;
		if ($urandom_range(0, 99) >= 8)
			offer(CMD_ARM, 8'($urandom));
		fr.push_back($urandom_range(0, 99) < 85 ? cfg_slave : 8'($urandom));
		if ($urandom_range(0, 99) < 15) begin
			fr.push_back(8'($urandom) | 8'h80);
			fr.push_back(8'($urandom));
		end else begin
			pick = $urandom_range(0, 99);
			n = pick < 10 ? $urandom_range(28, 255)
				: (pick < 30 ? $urandom_range(20, 27) : $urandom_range(0, 8));
			fr.push_back(8'($urandom_range(0, 127)));
			fr.push_back(8'(n));
			repeat (n > 27 ? $urandom_range(0, 3) : n) fr.push_back(8'($urandom));
		end
		crc = CRC_INIT;
		foreach (fr[i])
			crc = crc_fold(crc, fr[i]);
		fr.push_back(crc[7:0]);
		fr.push_back(crc[15:8]);
		if ($urandom_range(0, 99) < 8) begin
			k = fr.size() - 1 - $urandom_range(0, 1);
			fr[k] = fr[k] ^ 8'($urandom_range(1, 255));
		end
		keep = fr.size();
		if ($urandom_range(0, 99) < 5)
			keep = $urandom_range(1, fr.size() - 1);
		for (int i = 0; i < keep; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 4)
				offer(CMD_TICK, 8'($urandom));
			else if (pick < 6)
				offer(CMD_NONE, 8'($urandom));
			offer(CMD_BYTE, fr[i]);
		end
	endtask

	task automatic check_beat();
		rsp_t got;
		rsp_t want;
		got.is_reg = m_tuser[0];
		got.status = rsp_status_t'(m_tdata[2:0]);
		got.exc_code = m_tdata[10:3];
		got.reg_idx = m_tdata[14:11];
		got.reg_val = m_tdata[30:15];
		got.last = m_tlast;
		beats_out++;
		if (!got.is_reg && got.status <= ST_OVERFLOW)
			st_seen[got.status]++;
		if (awaited_rsp.size() == 0) begin
			$error("result beat with nothing expected: is_register %0d status %0d",
				got.is_reg, got.status);
			errors++;
			return;
		end
		want = awaited_rsp.pop_front();
		if (got.is_reg !== want.is_reg) begin
			$error("is_register: expected %0d, got %0d", want.is_reg, got.is_reg);
			errors++;
		end
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			errors++;
		end
		if (got.exc_code !== want.exc_code) begin
			$error("exception_code: expected %0h, got %0h", want.exc_code, got.exc_code);
			errors++;
		end
		if (got.reg_idx !== want.reg_idx) begin
			$error("reg_index: expected %0d, got %0d", want.reg_idx, got.reg_idx);
			errors++;
		end
		if (got.reg_val !== want.reg_val) begin
			$error("reg_value: expected %0h, got %0h", want.reg_val, got.reg_val);
			errors++;
		end
		if (got.last !== want.last) begin
			$error("last: expected %0d, got %0d", want.last, got.last);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_beat();
	end

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		m_tready = 1'b0;
		hold_left = 0;
		hold_used = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_req && !hold_used) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= calm || ($urandom_range(0, 99) >= 37);
			end
		end
	end

	initial begin
		#5000000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		logic [7:0]  data;
		logic [15:0] tx_crc;
		logic [15:0] crc_hold;
		logic [7:0]  ph_addr [PHASES];
		logic [15:0] ph_tmo [PHASES];
		int pick;
		int n;
		bit paused;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tuser = CMD_NONE;
		cfg_we = 1'b0;
		cfg_index = REG_SLAVE_ADDR;
		cfg_data = 16'h0000;
		calm = 1'b0;
		hold_req = 1'b0;
		errors = 0;
		beats_in = 0;
		items_taken = 0;
		beats_out = 0;
		settings = 1;
		foreach (st_seen[i])
			st_seen[i] = 0;
		foreach (rx_frame[i])
			rx_frame[i] = 8'h00;
		rx_len = 0;
		rd_busy = 1'b0;
		tick_cnt = 16'd0;
		cfg_slave = SLAVE_ADDR_RST;
		cfg_timeout = TIMEOUT_RST;
		tx_crc = CRC_INIT;
		crc_hold = CRC_INIT;

		// Register reset values hold for the table up to the timeout rows.
		plan = '{
			'{CMD_BYTE, 8'h55, CRC_NO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_TICK, 8'h00, CRC_NO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_NONE, 8'hFF, CRC_NO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_ARM,  8'h00, CRC_NO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_BYTE, 8'h01, CRC_NO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_BYTE, 8'h83, CRC_NO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_BYTE, 8'h0B, CRC_NO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_BYTE, 8'h00, CRC_LO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_BYTE, 8'h00, CRC_HI,  EXP_STATUS, ST_EXCEPT,   8'h0B},
			'{CMD_ARM,  8'h00, CRC_NO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_BYTE, 8'h00, CRC_NO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_BYTE, 8'h04, CRC_NO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_BYTE, 8'h00, CRC_NO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_BYTE, 8'h00, CRC_LO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_BYTE, 8'h00, CRC_HI,  EXP_STATUS, ST_BAD_ADDR, 8'h00},
			'{CMD_ARM,  8'h00, CRC_NO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_BYTE, 8'h01, CRC_NO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_BYTE, 8'h03, CRC_NO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_BYTE, 8'h00, CRC_NO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_BYTE, 8'h00, CRC_LO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_BYTE, 8'h00, CRC_BAD, EXP_STATUS, ST_CRC_ERR,  8'h00},
			'{CMD_ARM,  8'h00, CRC_NO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_BYTE, 8'h01, CRC_NO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_BYTE, 8'h03, CRC_NO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_BYTE, 8'hFF, CRC_NO,  EXP_STATUS, ST_OVERFLOW, 8'h00},
			'{CMD_ARM,  8'h00, CRC_NO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_BYTE, 8'h01, CRC_NO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_BYTE, 8'h03, CRC_NO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_BYTE, 8'h04, CRC_NO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_BYTE, 8'h00, CRC_NO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_BYTE, 8'h00, CRC_NO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_BYTE, 8'hFF, CRC_NO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_BYTE, 8'hFF, CRC_NO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_BYTE, 8'h00, CRC_LO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_BYTE, 8'h00, CRC_HI,  EXP_MODEL,  ST_OK,       8'h00},
			'{CMD_ARM,  8'h00, CRC_NO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_ARM,  8'h00, CRC_NO,  EXP_NONE,   ST_OK,       8'h00},
			'{CMD_TICK, 8'h00, CRC_NO,  EXP_STATUS, ST_TIMEOUT,  8'h00}
		};

		ph_addr = '{8'hFF, 8'h00, 8'h01, 8'($urandom), 8'hA5};
		ph_tmo = '{16'd65535, 16'd9, 16'd1, 16'($urandom_range(2, 60)), 16'd100};

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < PLAN_ROWS; r++) begin
			// The arm that follows finds nothing pending; the second one is
			// ignored, and a single tick then ends the read.
			if (r == TMO_ROW) begin
				drain();
				set_regs(8'h01, 16'd1);
			end
			data = plan[r].data;
			case (plan[r].crc)
				CRC_LO: begin
					crc_hold = tx_crc;
					data = crc_hold[7:0];
				end
				CRC_HI: data = crc_hold[15:8];
				CRC_BAD: data = ~crc_hold[15:8];
				default: ;
			endcase
			send_beat(plan[r].cmd, data, plan[r].how, plan[r].st, plan[r].exc);
			if (plan[r].cmd == CMD_ARM)
				tx_crc = CRC_INIT;
			else if (plan[r].cmd == CMD_BYTE)
				tx_crc = crc_fold(tx_crc, data);
		end
		drain();

		for (int p = 0; p < PHASES; p++) begin
			set_regs(ph_addr[p], ph_tmo[p]);
			calm = (p == 1);
			// The result side stalls for a long while as the first phase opens,
			// so the block backs up and holds off its input.
			if (p == 0)
				hold_req = 1'b1;
			phase_items = 0;
			paused = 1'b0;
			while (phase_items < PHASE_ITEMS) begin
				if (p == 3 && !paused && phase_items >= PHASE_ITEMS / 2) begin
					paused = 1'b1;
					drain();
				end
				pick = $urandom_range(0, 99);
				if (pick < 80) begin
					send_frame();
				end else if (pick < 90) begin
					repeat ($urandom_range(1, 5))
						offer(in_cmd_t'($urandom_range(0, 3)), 8'($urandom));
				end else begin
					n = cfg_timeout <= 28 ? cfg_timeout + $urandom_range(0, 2)
						: $urandom_range(1, 8);
					offer(CMD_ARM, 8'($urandom));
					repeat (n) offer(CMD_TICK, 8'($urandom));
				end
			end
			// Leave a read open with some ticks counted, so that the next
			// setting may find it already past a shorter timeout.
			offer(CMD_ARM, 8'h00);
			offer(CMD_TICK, 8'h00);
			drain();
		end
		calm = 1'b0;

		$display("Run covered %0d input beats, %0d of them acted on, under %0d settings.",
			beats_in, items_taken, settings);
		$display("Checked %0d result beats; ok/crc/addr/exc/timeout/overflow: %0d/%0d/%0d/%0d/%0d/%0d",
			beats_out, st_seen[0], st_seen[1], st_seen[2], st_seen[3], st_seen[4],
			st_seen[5]);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
